// ----- sv/scfd_pkg.sv -----
// Package for the serial CAN frame deframer.
// Holds frame constants, the decoded result type and the queue status type.
// No dependencies.
package scfd_pkg;

  localparam int FRAME_LEN   = 18;
  localparam int HELD_W      = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CMD_POS   = 1;
  localparam int FLAG_POS  = 3;
  localparam int ID_POS    = 4;
  localparam int DATA_POS  = 8;
  localparam int DATA_LEN  = 8;
  localparam int SUM_POS   = FRAME_LEN - 2;
  localparam int ETX_POS   = FRAME_LEN - 1;

  localparam logic [7:0] STX_BYTE   = 8'h02;
  localparam logic [7:0] ETX_BYTE   = 8'h03;
  localparam logic [7:0] CMD_CAN    = 8'h00;
  localparam logic [7:0] FLAG_STD_A = 8'h00;
  localparam logic [7:0] FLAG_STD_B = 8'h01;
  localparam logic [7:0] FLAG_EXT_A = 8'h40;
  localparam logic [7:0] FLAG_EXT_B = 8'h02;
  localparam logic [7:0] FLAG_EXT_C = 8'h03;

  typedef struct packed {
    logic [28:0] can_id;
    logic        is_extended;
    logic [63:0] payload;
  } scfd_frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } scfd_q_status_t;

endpackage

// ----- sv/serial_can_frame_deframer.sv -----
// Serial CAN frame deframer, top level.
// Instantiates scfd_front, scfd_queue and scfd_back; depends on scfd_pkg.
//
// The input channel takes one received serial byte per transfer on in_rx_byte.
// The block keeps a window of the last 18 bytes and looks for frames that open
// with 0x02, close with 0x03 and carry the mod-256 sum of bytes 1 to 15 in byte 16.
// A good frame with a zero command byte and a known flag yields one transfer on
// the result channel with the CAN identifier, the extended flag and eight data
// bytes. Other good frames are consumed without a result, and on a mismatch the
// search moves to the next start byte within the window.
// One byte is taken every cycle while in_stall is low; the whole window is checked
// and rescanned in the cycle of the transfer, and only a full queue holds the input.
// A result passes from the transfer of the closing byte through the frame queue
// and then the output register before it appears on out_valid.
// When the receiver stalls, the output register holds its result and up to two
// more results wait in the queue; in_stall rises only when that queue is full.
// Reset empties the window, the queue and the output register.
module serial_can_frame_deframer
  import scfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [28:0] out_can_id,
  output logic        out_is_extended,
  output logic [63:0] out_payload
);

  scfd_q_status_t q_status;
  scfd_frame_t    push_data;
  scfd_frame_t    head;
  logic           push;
  logic           pop;

  scfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  scfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  scfd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_can_id     (out_can_id),
    .out_is_extended(out_is_extended),
    .out_payload    (out_payload)
  );

endmodule

// ----- sv/scfd_front.sv -----
// Front part of the deframer: byte window, frame check, resynchronization and decode.
// Depends on scfd_pkg; pushes decoded CAN frames into scfd_queue.
module scfd_front
  import scfd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [7:0]     in_rx_byte,
  input  scfd_q_status_t q_status,
  output logic           push,
  output scfd_frame_t    push_data
);

  localparam logic [HELD_W-1:0] LAST_HELD = HELD_W'(FRAME_LEN - 1);

  logic [7:0]        sr_r [FRAME_LEN];
  logic [HELD_W-1:0] held_r;
  logic [HELD_W-1:0] held_nxt;
  logic [7:0]        win [FRAME_LEN];
  logic [7:0]        sum_l1 [8];
  logic [7:0]        sum_l2 [4];
  logic [7:0]        sum_l3 [2];
  logic [7:0]        sum;
  logic [HELD_W-1:0] rescan_held;
  logic              accept;
  logic              good;
  logic              is_std;
  logic              is_ext;
  logic              res_valid;
  scfd_frame_t       res;

  assign in_stall = q_status.full;
  assign accept   = in_valid && !q_status.full;

  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      win[i] = sr_r[i+1];
    end
    win[FRAME_LEN-1] = in_rx_byte;

    for (int i = 0; i < 7; i++) begin
      sum_l1[i] = win[2*i+1] + win[2*i+2];
    end
    sum_l1[7] = win[SUM_POS-1];
    for (int i = 0; i < 4; i++) begin
      sum_l2[i] = sum_l1[2*i] + sum_l1[2*i+1];
    end
    for (int i = 0; i < 2; i++) begin
      sum_l3[i] = sum_l2[2*i] + sum_l2[2*i+1];
    end
    sum = sum_l3[0] + sum_l3[1];
    good = (held_r == LAST_HELD) && (win[0] == STX_BYTE) &&
           (sum == win[SUM_POS]) && (win[ETX_POS] == ETX_BYTE);

    rescan_held = HELD_W'(1);
    for (int k = SUM_POS; k >= 1; k--) begin
      if (win[k] == STX_BYTE) begin
        rescan_held = HELD_W'(FRAME_LEN - k);
      end
    end

    priority if (held_r == '0) begin
      held_nxt = HELD_W'(1);
    end else if (held_r == HELD_W'(1)) begin
      held_nxt = (win[FRAME_LEN-2] == STX_BYTE) ? HELD_W'(2) : HELD_W'(1);
    end else if (held_r == LAST_HELD) begin
      held_nxt = good ? '0 : rescan_held;
    end else begin
      held_nxt = held_r + HELD_W'(1);
    end

    is_std = (win[FLAG_POS] == FLAG_STD_A) || (win[FLAG_POS] == FLAG_STD_B);
    is_ext = (win[FLAG_POS] == FLAG_EXT_A) || (win[FLAG_POS] == FLAG_EXT_B) ||
             (win[FLAG_POS] == FLAG_EXT_C);

    res.is_extended = is_ext;
    if (is_ext) begin
      res.can_id = {win[ID_POS][4:0], win[ID_POS+1], win[ID_POS+2], win[ID_POS+3]};
    end else begin
      res.can_id = {18'd0, win[ID_POS+1][2:0], win[ID_POS]};
    end
    for (int j = 0; j < DATA_LEN; j++) begin
      res.payload[63 - 8*j -: 8] = win[DATA_POS + j];
    end

    res_valid = good && (win[CMD_POS] == CMD_CAN) && (is_std || is_ext);
  end

  assign push      = accept && res_valid;
  assign push_data = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (accept) begin
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        sr_r[i] <= win[i];
      end
    end
  end

endmodule

// ----- sv/scfd_queue.sv -----
// Short queue of decoded CAN frames between the front and back parts.
// Depends on scfd_pkg for the frame and status types and the queue depth.
module scfd_queue
  import scfd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scfd_frame_t    push_data,
  input  logic           pop,
  output scfd_frame_t    head,
  output scfd_q_status_t status
);

  scfd_frame_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- sv/scfd_back.sv -----
// Back part of the deframer: output register that presents one CAN frame per transfer.
// Depends on scfd_pkg; pops frames from scfd_queue.
module scfd_back
  import scfd_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  scfd_frame_t    head,
  input  scfd_q_status_t q_status,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [28:0]    out_can_id,
  output logic           out_is_extended,
  output logic [63:0]    out_payload
);

  logic        out_valid_r;
  scfd_frame_t out_data_r;

  assign pop = !q_status.empty && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      out_valid_r <= !q_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= head;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_can_id      = out_data_r.can_id;
  assign out_is_extended = out_data_r.is_extended;
  assign out_payload     = out_data_r.payload;

endmodule
